### sv/tmi_pkg.sv
// Shared types, codes and defaults for the tape machine interpreter.
// No dependencies.
`default_nettype none
package tmi_pkg;

  localparam int unsigned PROG_DEPTH_DEF  = 1024;
  localparam int unsigned TAPE_CELLS_DEF  = 1024;
  localparam int unsigned NEST_DEPTH_DEF  = 256;
  localparam int unsigned INPUT_DEPTH_DEF = 16;

  typedef enum logic [2:0] {
    CMD_RIGHT, CMD_LEFT, CMD_INC, CMD_DEC, CMD_OUT, CMD_IN, CMD_OPEN, CMD_CLOSE
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK, ST_DONE, ST_OPEN_CLOSE, ST_OPEN_LEFT, ST_TAPE, ST_PROG_FULL, ST_NEST_FULL
  } status_e;

  typedef enum logic [1:0] {
    MODE_LOAD, MODE_PUSH, MODE_STEP, MODE_CLEAR
  } mode_e;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_POP, S_JMP2, S_EXEC, S_RESP
  } state_e;

  typedef struct packed {
    logic code_we;
    logic jump_we;
  } prog_we_t;

  function automatic logic is_cmd(input logic [7:0] ch);
    logic r;
    case (ch)
      8'h3E, 8'h3C, 8'h2B, 8'h2D, 8'h2E, 8'h2C, 8'h5B, 8'h5D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic cmd_e to_cmd(input logic [7:0] ch);
    cmd_e c;
    case (ch)
      8'h3E: c = CMD_RIGHT;
      8'h3C: c = CMD_LEFT;
      8'h2B: c = CMD_INC;
      8'h2D: c = CMD_DEC;
      8'h2E: c = CMD_OUT;
      8'h2C: c = CMD_IN;
      8'h5B: c = CMD_OPEN;
      default: c = CMD_CLOSE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### sv/tmi_prog_mem.sv
// Program store and jump partner memories, one shared write address,
// one shared read address, registered reads. Depends on tmi_pkg.
`default_nettype none
module tmi_prog_mem
  import tmi_pkg::*;
#(
  parameter int unsigned PROG_DEPTH = PROG_DEPTH_DEF,
  localparam int unsigned PW = $clog2(PROG_DEPTH)
) (
  input  wire logic            clk_i,
  input  wire prog_we_t        we_i,
  input  wire logic [PW-1:0]   waddr_i,
  input  wire cmd_e            wcode_i,
  input  wire logic [PW-1:0]   wjump_i,
  input  wire logic [PW-1:0]   raddr_i,
  output cmd_e                 rcode_o,
  output logic [PW-1:0]        rjump_o
);

  cmd_e        code_mem [PROG_DEPTH];
  logic [PW-1:0] jump_mem [PROG_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i.code_we) begin
      code_mem[waddr_i] <= wcode_i;
    end
    rcode_o <= code_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.jump_we) begin
      jump_mem[waddr_i] <= wjump_i;
    end
    rjump_o <= jump_mem[raddr_i];
  end

endmodule
`default_nettype wire

### sv/tmi_tape_mem.sv
// Byte tape memory, single port, registered read.
// Depends on tmi_pkg.
`default_nettype none
module tmi_tape_mem
  import tmi_pkg::*;
#(
  parameter int unsigned TAPE_CELLS = TAPE_CELLS_DEF,
  localparam int unsigned TW = $clog2(TAPE_CELLS)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [TW-1:0] addr_i,
  input  wire logic [7:0]    wdata_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem [TAPE_CELLS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

### sv/tape_machine_interpreter_step.sv
// Top level: sequencer, bracket stack, input FIFO and result register.
// Depends on tmi_pkg, tmi_prog_mem, tmi_tape_mem.
//
//  channel | signals                            | role
//  in      | in_valid_i in_ready_o mode_i data_byte_i | request: load, push, step, clear
//  res     | res_valid_o res_ready_i out_valid_o out_byte_o status_o | one per request
//
// Push and load respond from idle; a ']' load first writes both jump partners
// in S_POP and S_JMP2. Step reads program/jump and tape in idle, executes and
// writes back in S_EXEC, then responds. Reset and a clear start a sweep
// zeroing the tape with in_ready_o low. A pending result stalls only S_RESP.
`default_nettype none
module tape_machine_interpreter_step
  import tmi_pkg::*;
#(
  parameter int unsigned PROG_DEPTH  = PROG_DEPTH_DEF,
  parameter int unsigned TAPE_CELLS  = TAPE_CELLS_DEF,
  parameter int unsigned NEST_DEPTH  = NEST_DEPTH_DEF,
  parameter int unsigned INPUT_DEPTH = INPUT_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [7:0] data_byte_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      status_o
);

  localparam int unsigned PW = $clog2(PROG_DEPTH);
  localparam int unsigned LW = $clog2(PROG_DEPTH + 1);
  localparam int unsigned TW = $clog2(TAPE_CELLS);
  localparam int unsigned NW = $clog2(NEST_DEPTH);
  localparam int unsigned DW = $clog2(NEST_DEPTH + 1);
  localparam int unsigned IW = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int unsigned CW = $clog2(INPUT_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  state_e        state_q, state_d;
  logic [LW-1:0] plen_q, plen_d, pc_q, pc_d, pcn;
  logic [DW-1:0] depth_q, depth_d;
  logic [TW-1:0] cp_q, cp_d, clr_idx_q, clr_idx_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  status_e       halt_q, halt_d;
  logic          clr_next_q, clr_next_d;
  logic          res_valid_q, res_valid_d;

  logic [PW-1:0] sv_addr_q, sv_addr_d, open_q, open_d;
  logic          pov_q, pov_d, rov_q, rov_d;
  logic [7:0]    pob_q, pob_d, rob_q, rob_d;
  status_e       rst_q, rst_d;

  logic [PW-1:0] stack_q [NEST_DEPTH];
  logic [PW-1:0] stack_rd_q;
  logic          stack_we, stack_re;
  logic [NW-1:0] stack_addr;

  logic [7:0]    fifo_q [INPUT_DEPTH];
  logic          fifo_we;
  logic [IW-1:0] fifo_wa;
  logic [SW-1:0] fifo_sum;

  prog_we_t      p_we;
  logic [PW-1:0] p_waddr, p_wjump, p_rjump;
  cmd_e          p_wcode, p_rcode, cmd;
  logic          t_we;
  logic [TW-1:0] t_addr;
  logic [7:0]    t_wdata, t_rdata;
  logic          tape_halt;

  tmi_prog_mem #(.PROG_DEPTH(PROG_DEPTH)) u_prog (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wcode_i (p_wcode),
    .wjump_i (p_wjump),
    .raddr_i (pc_q[PW-1:0]),
    .rcode_o (p_rcode),
    .rjump_o (p_rjump)
  );

  tmi_tape_mem #(.TAPE_CELLS(TAPE_CELLS)) u_tape (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .addr_i  (t_addr),
    .wdata_i (t_wdata),
    .rdata_o (t_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;
  assign out_valid_o = rov_q;
  assign out_byte_o  = rob_q;
  assign status_o    = rst_q;

  always_comb begin
    fifo_sum = SW'(head_q) + SW'(cnt_q);
    if (fifo_sum >= SW'(INPUT_DEPTH)) begin
      fifo_sum = fifo_sum - SW'(INPUT_DEPTH);
    end
    fifo_wa = fifo_sum[IW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    plen_d      = plen_q;
    pc_d        = pc_q;
    depth_d     = depth_q;
    cp_d        = cp_q;
    clr_idx_d   = clr_idx_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    halt_d      = halt_q;
    clr_next_d  = clr_next_q;
    res_valid_d = res_valid_q && !res_ready_i;
    sv_addr_d   = sv_addr_q;
    open_d      = open_q;
    pov_d       = pov_q;
    pob_d       = pob_q;
    rov_d       = rov_q;
    rob_d       = rob_q;
    rst_d       = rst_q;
    stack_we    = 1'b0;
    stack_re    = 1'b0;
    stack_addr  = depth_q[NW-1:0];
    fifo_we     = 1'b0;
    p_we        = '0;
    p_waddr     = plen_q[PW-1:0];
    cmd         = to_cmd(data_byte_i);
    p_wcode     = cmd;
    p_wjump     = sv_addr_q;
    t_we        = 1'b0;
    t_addr      = cp_q;
    t_wdata     = 8'h00;
    tape_halt   = 1'b0;
    pcn         = pc_q;

    case (state_q)
      S_CLEAR: begin
        t_we   = 1'b1;
        t_addr = clr_idx_q;
        if (clr_idx_q == TW'(TAPE_CELLS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          pov_d   = 1'b0;
          pob_d   = 8'h00;
          state_d = S_RESP;
          case (mode_e'(mode_i))
            MODE_LOAD: begin
              if (halt_q == ST_OK && is_cmd(data_byte_i)) begin
                if (plen_q >= LW'(PROG_DEPTH)) begin
                  halt_d = ST_PROG_FULL;
                end else if (cmd == CMD_OPEN) begin
                  if (depth_q >= DW'(NEST_DEPTH)) begin
                    halt_d = ST_NEST_FULL;
                  end else begin
                    stack_we       = 1'b1;
                    depth_d        = depth_q + 1'b1;
                    p_we.code_we   = 1'b1;
                    plen_d         = plen_q + 1'b1;
                  end
                end else if (cmd == CMD_CLOSE) begin
                  if (depth_q == '0) begin
                    halt_d = ST_OPEN_CLOSE;
                  end else begin
                    depth_d      = depth_q - 1'b1;
                    stack_re     = 1'b1;
                    stack_addr   = depth_d[NW-1:0];
                    p_we.code_we = 1'b1;
                    sv_addr_d    = plen_q[PW-1:0];
                    plen_d       = plen_q + 1'b1;
                    state_d      = S_POP;
                  end
                end else begin
                  p_we.code_we = 1'b1;
                  plen_d       = plen_q + 1'b1;
                end
              end
            end
            MODE_PUSH: begin
              if (cnt_q < CW'(INPUT_DEPTH)) begin
                fifo_we = 1'b1;
                cnt_d   = cnt_q + 1'b1;
              end
            end
            MODE_STEP: begin
              if (halt_q == ST_OK) begin
                if (depth_q != '0) begin
                  halt_d = ST_OPEN_LEFT;
                end else if (pc_q >= plen_q) begin
                  halt_d = ST_DONE;
                end else begin
                  state_d = S_EXEC;
                end
              end
            end
            default: begin
              plen_d     = '0;
              pc_d       = '0;
              depth_d    = '0;
              cp_d       = TW'(TAPE_CELLS / 2);
              head_d     = '0;
              cnt_d      = '0;
              halt_d     = ST_OK;
              clr_next_d = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        open_d       = stack_rd_q;
        p_we.jump_we = 1'b1;
        p_waddr      = stack_rd_q;
        p_wjump      = sv_addr_q;
        state_d      = S_JMP2;
      end
      S_JMP2: begin
        p_we.jump_we = 1'b1;
        p_waddr      = sv_addr_q;
        p_wjump      = open_q;
        state_d      = S_RESP;
      end
      S_EXEC: begin
        case (p_rcode)
          CMD_RIGHT: begin
            if (cp_q == TW'(TAPE_CELLS - 1)) begin
              tape_halt = 1'b1;
            end else begin
              cp_d = cp_q + 1'b1;
            end
          end
          CMD_LEFT: begin
            if (cp_q == '0) begin
              tape_halt = 1'b1;
            end else begin
              cp_d = cp_q - 1'b1;
            end
          end
          CMD_INC: begin
            t_we    = 1'b1;
            t_wdata = t_rdata + 8'h01;
          end
          CMD_DEC: begin
            t_we    = 1'b1;
            t_wdata = t_rdata - 8'h01;
          end
          CMD_OUT: begin
            pov_d = 1'b1;
            pob_d = t_rdata;
          end
          CMD_IN: begin
            t_we = 1'b1;
            if (cnt_q != '0) begin
              t_wdata = fifo_q[head_q];
              head_d  = (head_q == IW'(INPUT_DEPTH - 1)) ? '0 : head_q + 1'b1;
              cnt_d   = cnt_q - 1'b1;
            end
          end
          CMD_OPEN: begin
            if (t_rdata == 8'h00) begin
              pcn = LW'(p_rjump);
            end
          end
          default: begin
            if (t_rdata != 8'h00) begin
              pcn = LW'(p_rjump);
            end
          end
        endcase
        if (tape_halt) begin
          halt_d = ST_TAPE;
        end else begin
          pc_d = pcn + 1'b1;
          if (pc_d >= plen_q) begin
            halt_d = ST_DONE;
          end
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!res_valid_q || res_ready_i) begin
          res_valid_d = 1'b1;
          rov_d       = pov_q;
          rob_d       = pob_q;
          rst_d       = halt_q;
          clr_idx_d   = '0;
          clr_next_d  = 1'b0;
          state_d     = clr_next_q ? S_CLEAR : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      plen_q      <= '0;
      pc_q        <= '0;
      depth_q     <= '0;
      cp_q        <= TW'(TAPE_CELLS / 2);
      clr_idx_q   <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      halt_q      <= ST_OK;
      clr_next_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plen_q      <= plen_d;
      pc_q        <= pc_d;
      depth_q     <= depth_d;
      cp_q        <= cp_d;
      clr_idx_q   <= clr_idx_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      halt_q      <= halt_d;
      clr_next_q  <= clr_next_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sv_addr_q <= sv_addr_d;
    open_q    <= open_d;
    pov_q     <= pov_d;
    pob_q     <= pob_d;
    rov_q     <= rov_d;
    rob_q     <= rob_d;
    rst_q     <= rst_d;
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_q[stack_addr] <= plen_q[PW-1:0];
    end
    if (stack_re) begin
      stack_rd_q <= stack_q[stack_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_q[fifo_wa] <= data_byte_i;
    end
  end

  a_fifo_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(INPUT_DEPTH)) else $error("input FIFO count overflow");
  a_nest_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(NEST_DEPTH)) else $error("bracket depth overflow");
  a_pc_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= plen_q) else $error("program counter beyond program");
  a_exec_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> (halt_q == ST_OK && depth_q == '0 && pc_q < plen_q))
    else $error("step executed while not runnable");
  a_no_accept_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o) else $error("request taken during sweep");

endmodule
`default_nettype wire

### sim/tape_machine_interpreter_step_test.sv
// Testbench for tape_machine_interpreter_step: random programs, input bytes and steps,
// with results checked against an in-bench interpreter kept in a scoreboard class.
// Depends on tmi_pkg and the tape_machine_interpreter_step RTL.
`timescale 1ns / 1ps

module tape_machine_interpreter_step_test;
  import tmi_pkg::*;

  localparam int unsigned PROG_N  = PROG_DEPTH_DEF;
  localparam int unsigned TAPE_N  = TAPE_CELLS_DEF;
  localparam int unsigned NEST_N  = NEST_DEPTH_DEF;
  localparam int unsigned FIFO_N  = INPUT_DEPTH_DEF;
  localparam int unsigned LIMIT   = 1500000;
  localparam int unsigned RAND_N  = 1150;

  typedef struct packed {
    logic       emit;
    logic [7:0] byte_val;
    status_e    st;
  } step_result_t;

  class tape_scoreboard;
    cmd_e         prog [PROG_N];
    logic [9:0]   partner [PROG_N];
    logic [9:0]   open_stack [NEST_N];
    int unsigned  depth, plen, pc, cp, fifo_cnt, fifo_head;
    logic [7:0]   tape [TAPE_N];
    logic [7:0]   fifo [FIFO_N];
    status_e      halt;
    step_result_t expected_results[$];
    int unsigned  errors, steps_run, bytes_out, halts_seen;

    function void clear_all();
      foreach (tape[i]) tape[i] = 8'd0;
      depth = 0; plen = 0; pc = 0; cp = TAPE_N / 2;
      fifo_cnt = 0; fifo_head = 0; halt = ST_OK;
    endfunction

    function void load_char(logic [7:0] ch);
      cmd_e c;
      if (!is_cmd(ch)) return;
      c = to_cmd(ch);
      if (plen >= PROG_N) begin
        halt = ST_PROG_FULL;
        return;
      end
      if (c == CMD_OPEN) begin
        if (depth >= NEST_N) begin
          halt = ST_NEST_FULL;
          return;
        end
        open_stack[depth] = plen[9:0];
        depth++;
      end else if (c == CMD_CLOSE) begin
        if (depth == 0) begin
          halt = ST_OPEN_CLOSE;
          return;
        end
        depth--;
        partner[open_stack[depth]] = plen[9:0];
        partner[plen] = open_stack[depth];
      end
      prog[plen] = c;
      plen++;
    endfunction

    function void exec_one(ref step_result_t r);
      int unsigned npc;
      npc = pc;
      steps_run++;
      if (depth != 0) begin
        halt = ST_OPEN_LEFT;
        return;
      end
      if (pc >= plen) begin
        halt = ST_DONE;
        return;
      end
      case (prog[pc])
        CMD_RIGHT: begin
          if (cp >= TAPE_N - 1) begin
            halt = ST_TAPE;
            return;
          end
          cp++;
        end
        CMD_LEFT: begin
          if (cp == 0) begin
            halt = ST_TAPE;
            return;
          end
          cp--;
        end
        CMD_INC: tape[cp] = tape[cp] + 8'd1;
        CMD_DEC: tape[cp] = tape[cp] - 8'd1;
        CMD_OUT: begin
          r.emit = 1'b1;
          r.byte_val = tape[cp];
          bytes_out++;
        end
        CMD_IN: begin
          if (fifo_cnt > 0) begin
            tape[cp] = fifo[fifo_head];
            fifo_head = (fifo_head + 1) % FIFO_N;
            fifo_cnt--;
          end else begin
            tape[cp] = 8'd0;
          end
        end
        CMD_OPEN: if (tape[cp] == 8'd0) npc = partner[pc];
        default: if (tape[cp] != 8'd0) npc = partner[pc];
      endcase
      pc = npc + 1;
      if (pc >= plen) halt = ST_DONE;
    endfunction

    function void note_request(mode_e m, logic [7:0] d);
      step_result_t r;
      status_e prev;
      r = '0;
      prev = halt;
      case (m)
        MODE_LOAD: if (halt == ST_OK) load_char(d);
        MODE_PUSH: begin
          if (fifo_cnt < FIFO_N) begin
            fifo[(fifo_head + fifo_cnt) % FIFO_N] = d;
            fifo_cnt++;
          end
        end
        MODE_STEP: if (halt == ST_OK) exec_one(r);
        default: clear_all();
      endcase
      if (prev == ST_OK && halt != ST_OK) halts_seen++;
      r.st = halt;
      expected_results = {expected_results, r};
    endfunction

    function void check_result(logic ov, logic [7:0] ob, logic [2:0] st);
      step_result_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_valid=%0d out_byte=%0d status=%0d", ov, ob, st);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (ov !== e.emit) begin
        $error("out_valid: expected %0d, got %0d", e.emit, ov);
        errors++;
      end
      if (ob !== e.byte_val) begin
        $error("out_byte: expected %0d, got %0d", e.byte_val, ob);
        errors++;
      end
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  mode_e      mode_i = MODE_LOAD;
  logic [7:0] data_byte_i = 8'd0;
  logic       res_valid_o;
  logic       res_ready_i = 1'b0;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [2:0] status_o;

  tape_scoreboard sb = new();
  bit          no_idle = 1'b0;
  bit          long_hold = 1'b0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;

  tape_machine_interpreter_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tape_machine_interpreter_step_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && res_valid_o && res_ready_i) sb.check_result(out_valid_o, out_byte_o, status_o);

  // result side: per-result stall, plus one long hold-off on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        res_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
          res_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      res_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(res_valid_o && res_ready_i));
    end
  end

  task automatic send(mode_e m, logic [7:0] d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    data_byte_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(m, d);
    items_sent++;
  endtask

  task automatic load_str(string s);
    foreach (s[i]) send(MODE_LOAD, s[i]);
  endtask

  task automatic load_random_program();
    int len, open;
    logic [7:0] ch;
    string ops;
    ops = "+-<>.,";
    open = 0;
    len = $urandom_range(1, 24);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 19))
        0: ch = 8'($urandom_range(0, 255));
        1, 2, 3: begin
          ch = (open < 4) ? "[" : "+";
          if (open < 4) open++;
        end
        4, 5: begin
          ch = (open > 0) ? "]" : "-";
          if (open > 0) open--;
        end
        default: ch = ops[$urandom_range(0, 5)];
      endcase
      send(MODE_LOAD, ch);
    end
    if ($urandom_range(0, 15) != 0) begin
      for (int i = 0; i < open; i++) begin
        send(MODE_LOAD, "]");
      end
    end
    if ($urandom_range(0, 15) == 0) begin
      send(MODE_LOAD, "]");
    end
  endtask

  task automatic run_until_halt();
    while (sb.halt == ST_OK) send(MODE_STEP, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int nsteps, pushes, phase;
    sb.clear_all();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send(MODE_LOAD, 8'hFF);
    send(MODE_LOAD, 8'h00);
    send(MODE_LOAD, "[");
    send(MODE_STEP, 8'h00);
    send(MODE_LOAD, "+");
    send(MODE_PUSH, 8'hFF);
    send(MODE_CLEAR, 8'h00);
    send(MODE_LOAD, "]");
    send(MODE_STEP, 8'h00);
    send(MODE_CLEAR, 8'hFF);
    load_str(",,.+-><[]");
    send(MODE_PUSH, 8'hA5);
    repeat (10) send(MODE_STEP, 8'h00);
    send(MODE_CLEAR, 8'h00);

    phase = 0;
    while (items_sent < RAND_N) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case (phase)
        0: begin
          // walk left in strides of 32 until the tape edge
          no_idle = 1'b1;
          load_str("+[");
          repeat (32) send(MODE_LOAD, "<");
          load_str("+]");
          run_until_halt();
        end
        1: begin
          no_idle = 1'b1;
          repeat (NEST_N + 1) send(MODE_LOAD, "[");
        end
        default: begin
          if (phase == 2) long_hold = 1'b1;
          load_random_program();
          pushes = $urandom_range(0, 18);
          repeat (pushes) begin
            send(MODE_PUSH, 8'($urandom_range(0, 255)));
          end
          nsteps = $urandom_range(1, 80);
          for (int i = 0; i < nsteps; i++) begin
            case ($urandom_range(0, 29))
              0, 1, 2: send(MODE_PUSH, 8'($urandom_range(0, 255)));
              3: send(MODE_LOAD, 8'($urandom_range(0, 255)));
              default: send(MODE_STEP, 8'($urandom_range(0, 255)));
            endcase
          end
        end
      endcase
      send(MODE_CLEAR, 8'($urandom_range(0, 255)));
      phase++;
    end
    in_valid_i <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("ran %0d requests over %0d program phases: %0d steps, %0d bytes emitted",
             items_sent, phase, sb.steps_run, sb.bytes_out);
    $display("%0d halts seen, including a tape edge and a full bracket nest", sb.halts_seen);
    if (sb.errors == 0) begin
      $display("tape_machine_interpreter_step_test: PASS");
    end else begin
      $display("tape_machine_interpreter_step_test: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
sv/tmi_pkg.sv
sv/tmi_prog_mem.sv
sv/tmi_tape_mem.sv
sv/tape_machine_interpreter_step.sv
sim/tape_machine_interpreter_step_test.sv
